### sv/length_prefixed_record_deframer_top_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the record deframer
// Clocked on clk, disabled while rst_n is low; empty when NO_ASSERTIONS is set.
// ----------------------------------------------------------------------------
`ifndef LENGTH_PREFIXED_RECORD_DEFRAMER_TOP_MACROS_SVH
`define LENGTH_PREFIXED_RECORD_DEFRAMER_TOP_MACROS_SVH

`ifndef NO_ASSERTIONS

// property must hold at every clock edge out of reset
`define LPRD_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// condition must never be seen at a clock edge out of reset
`define LPRD_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

`else

`define LPRD_ASSERT(label, prop, msg)
`define LPRD_NEVER(label, cond, msg)

`endif

`endif

### sv/lprd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lprd_pkg
// Types and constants shared by the record deframer.
// ----------------------------------------------------------------------------
package lprd_pkg;

    // string capacities in characters
    localparam int NAME_CAPACITY = 32;
    localparam int TEXT_CAPACITY = 256;

    // character counter is one bit wider than a position so 256 fits
    localparam int CNT_W = 9;

    // field kind codes on the result channel
    localparam logic [2:0] KIND_LENGTH = 3'd0;
    localparam logic [2:0] KIND_NAME   = 3'd1;
    localparam logic [2:0] KIND_TEXT   = 3'd2;
    localparam logic [2:0] KIND_INT1   = 3'd3;
    localparam logic [2:0] KIND_INT2   = 3'd4;

    // parse phase of the current record
    typedef enum logic [2:0] {
        PH_LENGTH = 3'd0,
        PH_NAME   = 3'd1,
        PH_TEXT   = 3'd2,
        PH_INT1   = 3'd3,
        PH_INT2   = 3'd4
    } phase_t;

    // one result item
    typedef struct packed {
        logic [2:0]  kind;
        logic [31:0] value;
        logic [7:0]  pos;
        logic        ovf;
        logic        last;
    } result_t;

endpackage

### sv/length_prefixed_record_deframer_top.sv
`timescale 1ns / 1ps
// A result is written to the output register (to skid if it is held) as the
// byte that completes it is accepted.
// Throughput: one byte per cycle while the skid is empty; a two-entry output
// buffer (result register plus skid) lets bytes flow while one result waits.
// Reset: rst_n clears the parser to expect a length field and empties the
// output buffer.
// ----------------------------------------------------------------------------
// length_prefixed_record_deframer_top
// Parses a byte stream of length-prefixed records into length, string
// character and integer requests.
// ----------------------------------------------------------------------------
`include "length_prefixed_record_deframer_top_macros.svh"

module length_prefixed_record_deframer_top (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               byte_valid,
    output logic               byte_stall,
    input  logic [7:0]         data_byte,
    output logic               field_valid,
    input  logic               field_stall,
    output logic [2:0]         field_kind,
    output logic signed [31:0] field_value,
    output logic [7:0]         char_position,
    output logic               string_overflow,
    output logic               last_of_record
);
    import lprd_pkg::*;

    // parser state
    phase_t                 phase_reg, phase_next;
    logic [1:0]             byte_in_word_reg, byte_in_word_next;
    logic [31:0]            word_shift_reg, word_shift_next;
    logic [CNT_W-1:0]       string_count_reg, string_count_next;
    logic                   overflow_seen_reg, overflow_seen_next;

    // output buffer
    result_t                main_reg, skid_reg;
    logic                   main_valid_reg, skid_valid_reg;

    logic                   accept;
    logic                   take;
    logic                   res_valid;
    result_t                res;
    logic [31:0]            word_full;
    logic [CNT_W-1:0]       cap;
    logic [2:0]             str_kind;
    logic                   in_string;

    assign accept     = byte_valid && !byte_stall;
    assign take       = main_valid_reg && !field_stall;
    assign byte_stall = skid_valid_reg;
    assign in_string  = (phase_reg == PH_NAME) || (phase_reg == PH_TEXT);

    // merge the byte into the partial little-endian word
    assign word_full = word_shift_reg | ({24'd0, data_byte} << {byte_in_word_reg, 3'b000});

    // parse one byte
    always_comb
    begin
        phase_next         = phase_reg;
        byte_in_word_next  = byte_in_word_reg;
        word_shift_next    = word_shift_reg;
        string_count_next  = string_count_reg;
        overflow_seen_next = overflow_seen_reg;
        res_valid          = 1'b0;
        res.kind           = KIND_LENGTH;
        res.value          = word_full;
        res.pos            = 8'd0;
        res.ovf            = overflow_seen_reg;
        res.last           = 1'b0;
        cap                = CNT_W'(NAME_CAPACITY);
        str_kind           = KIND_NAME;

        case (phase_reg)
            PH_NAME, PH_TEXT:
            begin
                if (phase_reg == PH_TEXT)
                begin
                    cap      = CNT_W'(TEXT_CAPACITY);
                    str_kind = KIND_TEXT;
                end
                if (data_byte == 8'd0)
                begin
                    // terminator: move to the next field
                    phase_next        = (phase_reg == PH_NAME) ? PH_TEXT : PH_INT1;
                    string_count_next = '0;
                end
                else if (string_count_reg < cap)
                begin
                    res_valid         = 1'b1;
                    res.kind          = str_kind;
                    res.value         = {24'd0, data_byte};
                    res.pos           = string_count_reg[7:0];
                    string_count_next = string_count_reg + CNT_W'(1);
                end
                else
                begin
                    // drop the character and flag the record
                    overflow_seen_next = 1'b1;
                end
            end
            default:
            begin
                // integer phases; unused codes act as the length phase
                if (byte_in_word_reg != 2'd3)
                begin
                    word_shift_next   = word_full;
                    byte_in_word_next = byte_in_word_reg + 2'd1;
                    if (phase_reg != PH_INT1 && phase_reg != PH_INT2)
                    begin
                        phase_next = PH_LENGTH;
                    end
                end
                else
                begin
                    word_shift_next   = '0;
                    byte_in_word_next = 2'd0;
                    res_valid         = 1'b1;
                    if (phase_reg == PH_INT1)
                    begin
                        res.kind   = KIND_INT1;
                        phase_next = PH_INT2;
                    end
                    else if (phase_reg == PH_INT2)
                    begin
                        res.kind           = KIND_INT2;
                        res.last           = 1'b1;
                        phase_next         = PH_LENGTH;
                        overflow_seen_next = 1'b0;
                        string_count_next  = '0;
                    end
                    else
                    begin
                        res.kind          = KIND_LENGTH;
                        phase_next        = PH_NAME;
                        string_count_next = '0;
                    end
                end
            end
        endcase
    end

    // advance parser state on each accepted byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= PH_LENGTH;
            byte_in_word_reg  <= 2'd0;
            word_shift_reg    <= '0;
            string_count_reg  <= '0;
            overflow_seen_reg <= 1'b0;
        end
        else if (accept)
        begin
            phase_reg         <= phase_next;
            byte_in_word_reg  <= byte_in_word_next;
            word_shift_reg    <= word_shift_next;
            string_count_reg  <= string_count_next;
            overflow_seen_reg <= overflow_seen_next;
        end
    end

    // hold results in the output register, spill to skid when it is stalled
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (accept && res_valid)
        begin
            if (!main_valid_reg || take)
            begin
                main_valid_reg <= 1'b1;
            end
            else
            begin
                skid_valid_reg <= 1'b1;
            end
        end
        else if (take)
        begin
            if (skid_valid_reg)
            begin
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                main_valid_reg <= 1'b0;
            end
        end
    end

    // payload of the output buffer
    always_ff @(posedge clk)
    begin
        if (accept && res_valid)
        begin
            if (!main_valid_reg || take)
            begin
                main_reg <= res;
            end
            else
            begin
                skid_reg <= res;
            end
        end
        else if (take && skid_valid_reg)
        begin
            main_reg <= skid_reg;
        end
    end

    assign field_valid     = main_valid_reg;
    assign field_kind      = main_reg.kind;
    assign field_value     = $signed(main_reg.value);
    assign char_position   = main_reg.pos;
    assign string_overflow = main_reg.ovf;
    assign last_of_record  = main_reg.last;

    // skid holds a request only behind a full output register
    `LPRD_ASSERT(a_skid_behind_main, skid_valid_reg |-> main_valid_reg, "skid full, main empty")
    // second integer always closes the record
    `LPRD_ASSERT(a_int2_last, field_valid && field_kind == KIND_INT2 |-> last_of_record, "last missing")
    // character count is idle outside the string phases
    `LPRD_NEVER(n_count_outside_str, !in_string && string_count_reg != '0, "string count leaked")
    // word assembly is idle inside the string phases
    `LPRD_NEVER(n_word_in_str, in_string && byte_in_word_reg != 2'd0, "word count in string")

endmodule
